FILE: sv/swm_pkg.sv
// Shared types and constants for the sliding window median filter.
// Used by the compare cells, the middle selector, the top level and the checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

   localparam int SAMPLE_W = 32;
   localparam int MEDIAN_W = 33;
   localparam int WL_W     = 7;
   localparam int CSR_W    = 32;
   localparam int ADDR_W   = 3;

   localparam logic [WL_W-1:0] WL_RESET = 7'd3;

   // Register index decoded from paddr[2] (one 32-bit register per word).
   localparam logic REG_WINDOW_LEN = 1'b0;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [MEDIAN_W-1:0] median_type;

   // Broadcast to every cell for one transfer.
   typedef struct packed {
      logic                       enable;
      logic                       evict;
      logic signed [SAMPLE_W-1:0] sample;
      logic signed [SAMPLE_W-1:0] oldest;
   } cell_ctl_type;

   // Handed from a cell to its right-hand neighbor.
   typedef struct packed {
      logic                       ins_gt;
      logic signed [SAMPLE_W-1:0] val;
   } cell_fwd_type;

   // Handed from a cell to its left-hand neighbor.
   typedef struct packed {
      logic                       valid;
      logic                       eq_old;
      logic                       gt_new;
      logic signed [SAMPLE_W-1:0] val;
   } cell_bwd_type;

endpackage

`default_nettype wire

FILE: sv/swm_cell.sv
// One slot of the sorted window: removes the oldest sample and inserts the new one.
// Talks only to its two neighbors and to the broadcast control.
// Depends on swm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swm_cell (
   input  wire                  clock,
   input  swm_pkg::cell_ctl_type ctl,
   input  wire                  valid,
   input  swm_pkg::cell_fwd_type from_left,
   input  swm_pkg::cell_bwd_type from_right,
   output swm_pkg::cell_fwd_type to_right,
   output swm_pkg::cell_bwd_type to_left,
   output swm_pkg::sample_type   val
);

   swm_pkg::sample_type val_ff;
   swm_pkg::sample_type val_in;

   logic eq_old;
   logic gt_old;
   logic gt_new;
   logic remove;
   logic shift;
   logic valid_post;
   logic ins_gt;
   swm_pkg::sample_type post_val;

   always_comb begin
      eq_old = valid && (val_ff == ctl.oldest);
      gt_old = $signed(val_ff) > $signed(ctl.oldest);
      gt_new = $signed(val_ff) > $signed(ctl.sample);

      // The evicted entry is the last one equal to the oldest sample, so every
      // cell at or above it can tell from its own value that it moves down.
      remove = ctl.evict && eq_old && !from_right.eq_old;
      shift  = ctl.evict && valid && (gt_old || remove);

      post_val   = shift ? from_right.val : val_ff;
      valid_post = ctl.evict ? from_right.valid : valid;
      ins_gt     = valid_post && (shift ? from_right.gt_new : gt_new);

      priority if (from_left.ins_gt) begin
         val_in = from_left.val;
      end else if (ins_gt || !valid_post) begin
         val_in = ctl.sample;
      end else begin
         val_in = post_val;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.enable) begin
         val_ff <= val_in;
      end
   end

   assign to_right.ins_gt = ins_gt;
   assign to_right.val    = post_val;
   assign to_left.valid   = valid;
   assign to_left.eq_old  = eq_old;
   assign to_left.gt_new  = gt_new;
   assign to_left.val     = val_ff;
   assign val             = val_ff;

endmodule

`default_nettype wire

FILE: sv/swm_mid_sel.sv
// Picks the two middle entries of the sorted cell row into a register stage.
// Depends on swm_pkg; fed by the cell row in the top level.
`timescale 1ns / 1ps
`default_nettype none

module swm_mid_sel #(
   parameter int WINDOW_MAX = 64
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   load,
   input  wire                                   drain,
   input  wire [$clog2(WINDOW_MAX+1)-1:0]        count,
   input  wire                                   last,
   input  swm_pkg::sample_type                   vals [WINDOW_MAX],
   output logic                                  mid_valid,
   output swm_pkg::sample_type                   lo_val,
   output swm_pkg::sample_type                   hi_val,
   output logic                                  mid_last
);

   localparam int CNT_W = $clog2(WINDOW_MAX + 1);
   localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

   logic                valid_ff;
   logic                valid_in;
   swm_pkg::sample_type lo_ff;
   swm_pkg::sample_type hi_ff;
   logic                last_ff;

   logic [CNT_W-1:0] lo_pos;
   logic [CNT_W-1:0] hi_pos;
   logic [PTR_W-1:0] lo_idx;
   logic [PTR_W-1:0] hi_idx;

   // For an odd count both indexes land on the same middle entry.
   always_comb begin
      lo_pos = (count - CNT_W'(1)) >> 1;
      hi_pos = count >> 1;
      lo_idx = lo_pos[PTR_W-1:0];
      hi_idx = hi_pos[PTR_W-1:0];
   end

   always_comb begin
      priority if (load) begin
         valid_in = 1'b1;
      end else if (drain) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         lo_ff   <= vals[lo_idx];
         hi_ff   <= vals[hi_idx];
         last_ff <= last;
      end
   end

   assign mid_valid = valid_ff;
   assign lo_val    = lo_ff;
   assign hi_val    = hi_ff;
   assign mid_last  = last_ff;

endmodule

`default_nettype wire

FILE: sv/sliding_window_median.sv
// Sliding window median filter. Takes one signed 32-bit sample per clock while
// req_stall is low and, once window_len samples of the sequence are held, returns
// twice the window median (the sum of the two middle values for an even count) for
// every sample. A sample flagged as the end of its sequence always returns a
// result, over whatever samples are held, and then clears the window. The sorted
// window lives in a row of WINDOW_MAX compare cells that evict the oldest sample
// and insert the new one in the same cycle whatever the window length, so the
// block sustains one transfer per cycle while not stalled; the result leaves
// through a middle-entry select stage and a sum stage. Writing window_len clears
// the window. Depends on swm_pkg, swm_cell and swm_mid_sel.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_median #(
   parameter int WINDOW_MAX = 64
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire signed [31:0]             req_sample,
   input  wire                           req_seq_end,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output logic signed [32:0]            rsp_median_doubled,
   output logic                          rsp_end_of_sequence,
   input  wire                           psel,
   input  wire                           penable,
   input  wire                           pwrite,
   input  wire [swm_pkg::ADDR_W-1:0]     paddr,
   input  wire [swm_pkg::CSR_W-1:0]      pwdata,
   output logic [swm_pkg::CSR_W-1:0]     prdata,
   output logic                          pready
);

   localparam int CNT_W = $clog2(WINDOW_MAX + 1);
   localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int LEN_W = (CNT_W > swm_pkg::WL_W) ? CNT_W : swm_pkg::WL_W;

   // Configuration register.
   logic [swm_pkg::WL_W-1:0] window_len_ff;
   logic [swm_pkg::WL_W-1:0] window_len_in;
   logic                     csr_write;

   // Window bookkeeping.
   logic [CNT_W-1:0]    fill_ff;
   logic [CNT_W-1:0]    fill_in;
   logic [PTR_W-1:0]    ptr_ff;
   logic [PTR_W-1:0]    ptr_in;
   logic                use_rd_ff;
   logic                use_rd_in;
   swm_pkg::sample_type oldest_ff;
   swm_pkg::sample_type oldest_in;
   swm_pkg::sample_type ring_rd_ff;
   swm_pkg::sample_type ring_mem [WINDOW_MAX];

   // Result waiting to be picked out of the cell row.
   logic             pend_ff;
   logic             pend_in;
   logic [CNT_W-1:0] pend_n_ff;
   logic [CNT_W-1:0] pend_n_in;
   logic             pend_last_ff;
   logic             pend_last_in;

   // Output register.
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   swm_pkg::median_type  median_ff;
   swm_pkg::median_type  median_in;
   logic                 end_ff;

   logic [LEN_W-1:0]  wl_ext;
   logic [CNT_W-1:0]  len_eff;
   logic              full;
   logic              emit;
   logic [CNT_W-1:0]  fill_new;
   logic [CNT_W-1:0]  slot_inc;
   logic [PTR_W-1:0]  nxt_ptr;
   logic [PTR_W-1:0]  wr_addr;
   swm_pkg::sample_type oldest_val;

   logic accept;
   logic en_out;
   logic en_mid;
   logic load_mid;

   logic                mid_valid;
   swm_pkg::sample_type lo_val;
   swm_pkg::sample_type hi_val;
   logic                mid_last;

   swm_pkg::cell_ctl_type ctl;
   swm_pkg::cell_fwd_type fwd  [WINDOW_MAX];
   swm_pkg::cell_bwd_type bwd  [WINDOW_MAX];
   swm_pkg::sample_type   vals [WINDOW_MAX];

   // ------------------------------------------------------------------
   // Configuration port
   // ------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready
                      && (paddr[2] == swm_pkg::REG_WINDOW_LEN);

   always_comb begin
      window_len_in = csr_write ? pwdata[swm_pkg::WL_W-1:0] : window_len_ff;
      prdata        = (paddr[2] == swm_pkg::REG_WINDOW_LEN)
                      ? swm_pkg::CSR_W'(window_len_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= swm_pkg::WL_RESET;
      end else begin
         window_len_ff <= window_len_in;
      end
   end

   // ------------------------------------------------------------------
   // Handshake and pipeline control
   // ------------------------------------------------------------------
   always_comb begin
      en_out    = !rsp_valid_ff || !rsp_stall;
      en_mid    = !mid_valid || en_out;
      req_stall = pend_ff && !en_mid;
      accept    = req_valid && !req_stall;
      load_mid  = pend_ff && en_mid;
   end

   // ------------------------------------------------------------------
   // Window bookkeeping
   // ------------------------------------------------------------------
   always_comb begin
      wl_ext = LEN_W'(window_len_ff);
      if (wl_ext == '0) begin
         len_eff = CNT_W'(1);
      end else if (wl_ext > LEN_W'(WINDOW_MAX)) begin
         len_eff = CNT_W'(WINDOW_MAX);
      end else begin
         len_eff = wl_ext[CNT_W-1:0];
      end

      full     = fill_ff >= len_eff;
      fill_new = full ? fill_ff : fill_ff + CNT_W'(1);
      emit     = full || (fill_new >= len_eff) || req_seq_end;

      slot_inc = CNT_W'(ptr_ff) + CNT_W'(1);
      nxt_ptr  = (slot_inc >= len_eff) ? '0 : slot_inc[PTR_W-1:0];
      wr_addr  = full ? ptr_ff : fill_ff[PTR_W-1:0];

      oldest_val = use_rd_ff ? ring_rd_ff : oldest_ff;
   end

   always_comb begin
      fill_in   = fill_ff;
      ptr_in    = ptr_ff;
      use_rd_in = use_rd_ff;
      oldest_in = oldest_ff;
      if (csr_write) begin
         fill_in = '0;
         ptr_in  = '0;
      end else if (accept) begin
         fill_in   = req_seq_end ? '0 : fill_new;
         ptr_in    = (req_seq_end || !full) ? '0 : nxt_ptr;
         // When full, next oldest is read from the ring, but a one-sample window
         // uses the sample written now; a first sample is kept as the oldest.
         use_rd_in = full && (nxt_ptr != ptr_ff);
         if ((full && (nxt_ptr == ptr_ff)) || (!full && (fill_ff == '0))) begin
            oldest_in = req_sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         ptr_ff    <= '0;
         use_rd_ff <= 1'b0;
      end else begin
         fill_ff   <= fill_in;
         ptr_ff    <= ptr_in;
         use_rd_ff <= use_rd_in;
      end
   end

   always_ff @(posedge clock) begin
      oldest_ff <= oldest_in;
   end

   // Arrival ring: one write and one registered read per transfer.
   always_ff @(posedge clock) begin
      if (accept) begin
         ring_mem[wr_addr] <= req_sample;
         ring_rd_ff        <= ring_mem[nxt_ptr];
      end
   end

   // ------------------------------------------------------------------
   // Cell row
   // ------------------------------------------------------------------
   assign ctl.enable = accept;
   assign ctl.evict  = full;
   assign ctl.sample = req_sample;
   assign ctl.oldest = oldest_val;

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      swm_pkg::cell_fwd_type left_in;
      swm_pkg::cell_bwd_type right_in;
      logic                  cell_valid;

      assign cell_valid = fill_ff > CNT_W'(i);

      if (i == 0) begin : g_first
         assign left_in.ins_gt = 1'b0;
         assign left_in.val    = '0;
      end else begin : g_mid_l
         assign left_in = fwd[i-1];
      end

      if (i == WINDOW_MAX - 1) begin : g_last
         assign right_in.valid  = 1'b0;
         assign right_in.eq_old = 1'b0;
         assign right_in.gt_new = 1'b0;
         assign right_in.val    = '0;
      end else begin : g_mid_r
         assign right_in = bwd[i+1];
      end

      swm_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .valid      (cell_valid),
         .from_left  (left_in),
         .from_right (right_in),
         .to_right   (fwd[i]),
         .to_left    (bwd[i]),
         .val        (vals[i])
      );
   end

   // ------------------------------------------------------------------
   // Result pipeline
   // ------------------------------------------------------------------
   always_comb begin
      pend_n_in    = pend_n_ff;
      pend_last_in = pend_last_ff;
      if (accept) begin
         pend_in      = emit;
         pend_n_in    = fill_new;
         pend_last_in = req_seq_end;
      end else if (load_mid) begin
         pend_in = 1'b0;
      end else begin
         pend_in = pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_n_ff    <= pend_n_in;
      pend_last_ff <= pend_last_in;
   end

   swm_mid_sel #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_mid_sel (
      .clock     (clock),
      .reset     (reset),
      .load      (load_mid),
      .drain     (en_out),
      .count     (pend_n_ff),
      .last      (pend_last_ff),
      .vals      (vals),
      .mid_valid (mid_valid),
      .lo_val    (lo_val),
      .hi_val    (hi_val),
      .mid_last  (mid_last)
   );

   always_comb begin
      median_in    = {lo_val[31], lo_val} + {hi_val[31], hi_val};
      rsp_valid_in = en_out ? mid_valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out && mid_valid) begin
         median_ff <= median_in;
         end_ff    <= mid_last;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_median_doubled  = median_ff;
   assign rsp_end_of_sequence = end_ff;

endmodule

`default_nettype wire

FILE: sv/swm_checker.sv
// Port-level checks for the sliding window median filter, bound to its top level.
// Depends on swm_pkg and sliding_window_median.
`timescale 1ns / 1ps
`default_nettype none

module swm_checker (
   input wire                       clock,
   input wire                       reset,
   input wire                       req_stall,
   input wire                       rsp_valid,
   input wire                       rsp_stall,
   input wire [swm_pkg::MEDIAN_W-1:0] rsp_median_doubled,
   input wire                       rsp_end_of_sequence
);

   // A result offered under stall stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // A stalled result keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_median_doubled) && $stable(rsp_end_of_sequence))
      else $error("result payload changed while stalled");

   // The input side only backs up when a finished result cannot leave.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with the output free");

   // Reset leaves nothing in flight.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result or stall present after reset");

endmodule

bind sliding_window_median swm_checker u_swm_checker (
   .clock               (clock),
   .reset               (reset),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_median_doubled  (rsp_median_doubled),
   .rsp_end_of_sequence (rsp_end_of_sequence)
);

`default_nettype wire

FILE: tb/swm_median_checker.sv
// Checker for the sliding window median filter: watches the sample, result and
// register channels, predicts each median and compares it with the block's output.
// Depends on swm_pkg.
`timescale 1ns / 1ps

module swm_median_checker (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   input  wire                            req_stall,
   input  wire signed [31:0]              req_sample,
   input  wire                            req_seq_end,
   input  wire                            rsp_valid,
   input  wire                            rsp_stall,
   input  wire signed [32:0]              rsp_median_doubled,
   input  wire                            rsp_end_of_sequence,
   input  wire                            psel,
   input  wire                            penable,
   input  wire                            pwrite,
   input  wire                            pready,
   input  wire [swm_pkg::ADDR_W-1:0]      paddr,
   input  wire [swm_pkg::CSR_W-1:0]       pwdata,
   output int                             fail_count,
   output int                             open_results
);

   localparam int WINDOW_MAX = 64;

   typedef struct packed {
      swm_pkg::median_type median;
      logic                eos;
   } median_result_type;

   median_result_type due_medians[$];

   swm_pkg::sample_type       arrival[WINDOW_MAX];
   swm_pkg::sample_type       ordered[WINDOW_MAX];
   int                        held = 0;
   int                        head = 0;
   logic [swm_pkg::WL_W-1:0]  win_len = swm_pkg::WL_RESET;
   int                        fails = 0;

   initial begin
      fail_count   = 0;
      open_results = 0;
   end

   // Out-of-range lengths saturate: zero behaves as one, anything larger than
   // the cell row behaves as the full row.
   function automatic int span();
      if (win_len == 0) return 1;
      if (win_len > WINDOW_MAX) return WINDOW_MAX;
      return int'(win_len);
   endfunction

   function automatic void drop_sorted(swm_pkg::sample_type v);
      for (int j = 0; j < held; j++) begin
         if (ordered[j] == v) begin
            for (int k = j; k + 1 < held; k++) ordered[k] = ordered[k + 1];
            held--;
            return;
         end
      end
   endfunction

   function automatic void add_sorted(swm_pkg::sample_type v);
      int p;
      p = 0;
      while (p < held && ordered[p] <= v) p++;
      for (int j = held; j > p; j--) ordered[j] = ordered[j - 1];
      ordered[p] = v;
      held++;
   endfunction

   function automatic swm_pkg::median_type doubled_median();
      longint m;
      if (held % 2 == 1)
         m = 2 * longint'(ordered[held / 2]);
      else
         m = longint'(ordered[held / 2 - 1]) + longint'(ordered[held / 2]);
      return swm_pkg::median_type'(m[swm_pkg::MEDIAN_W-1:0]);
   endfunction

   function automatic void predict_sample(swm_pkg::sample_type s, logic ends);
      int                len;
      int                slot;
      bit                emit;
      median_result_type r;
      len = span();
      if (held >= len) begin
         slot = (head >= len) ? 0 : head;
         drop_sorted(arrival[slot]);
         arrival[slot] = s;
         add_sorted(s);
         slot++;
         head = (slot >= len) ? 0 : slot;
         emit = 1'b1;
      end else begin
         arrival[held] = s;
         add_sorted(s);
         emit = (held >= len) || ends;
      end
      if (emit) begin
         r.median = doubled_median();
         r.eos    = ends;
         due_medians.insert(due_medians.size(), r);
         if (ends) begin
            held = 0;
            head = 0;
         end
      end
   endfunction

   always @(posedge clock) begin
      median_result_type want;
      if (reset) begin
         held    = 0;
         head    = 0;
         win_len = swm_pkg::WL_RESET;
         due_medians.delete();
      end else begin
         // Results are handled before the sample of this edge: the block's
         // latency keeps a sample from answering in its own cycle.
         if (rsp_valid && !rsp_stall) begin
            if (due_medians.size() == 0) begin
               $error("unexpected result transfer: median_doubled %0d, end_of_sequence %0d",
                      rsp_median_doubled, rsp_end_of_sequence);
               fails++;
            end else begin
               want = due_medians.pop_front();
               if (rsp_median_doubled !== want.median) begin
                  $error("median_doubled: expected %0d, actual %0d",
                         want.median, rsp_median_doubled);
                  fails++;
               end
               if (rsp_end_of_sequence !== want.eos) begin
                  $error("end_of_sequence: expected %0d, actual %0d",
                         want.eos, rsp_end_of_sequence);
                  fails++;
               end
            end
         end
         if (psel && penable && pwrite && pready
             && paddr[2] == swm_pkg::REG_WINDOW_LEN) begin
            win_len = pwdata[swm_pkg::WL_W-1:0];
            held    = 0;
            head    = 0;
         end
         if (req_valid && !req_stall) predict_sample(req_sample, req_seq_end);
      end
      fail_count   <= fails;
      open_results <= due_medians.size();
   end

endmodule

FILE: tb/tb.sv
// Top of the sliding window median testbench: clock, reset, register writes and
// sample stimulus, with the verdict at the end.
// Depends on swm_pkg, sliding_window_median and swm_median_checker.
`timescale 1ns / 1ps

module tb;

   localparam int                  LIMIT     = 200000;
   localparam logic                SPARE_REG = 1'b1;
   localparam swm_pkg::sample_type S_MIN     = 32'sh8000_0000;
   localparam swm_pkg::sample_type S_MAX     = 32'sh7fff_ffff;

   logic                          clock;
   logic                          reset       = 1'b1;
   logic                          req_valid   = 1'b0;
   wire                           req_stall;
   swm_pkg::sample_type           req_sample  = '0;
   logic                          req_seq_end = 1'b0;
   wire                           rsp_valid;
   logic                          rsp_stall   = 1'b0;
   wire signed [32:0]             rsp_median_doubled;
   wire                           rsp_end_of_sequence;
   logic                          psel        = 1'b0;
   logic                          penable     = 1'b0;
   logic                          pwrite      = 1'b0;
   logic [swm_pkg::ADDR_W-1:0]    paddr       = '0;
   logic [swm_pkg::CSR_W-1:0]     pwdata      = '0;
   wire  [swm_pkg::CSR_W-1:0]     prdata;
   wire                           pready;

   bit                   steady = 1'b0;
   int                   cycles = 0;
   int                   fail_count;
   int                   open_results;

   sliding_window_median i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_sample          (req_sample),
      .req_seq_end         (req_seq_end),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_median_doubled  (rsp_median_doubled),
      .rsp_end_of_sequence (rsp_end_of_sequence),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   swm_median_checker i_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_sample          (req_sample),
      .req_seq_end         (req_seq_end),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_median_doubled  (rsp_median_doubled),
      .rsp_end_of_sequence (rsp_end_of_sequence),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .pready              (pready),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .fail_count          (fail_count),
      .open_results        (open_results)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < 13);
   end

   task automatic push_sample(input swm_pkg::sample_type s, input logic ends);
      while (!steady && $urandom_range(0, 99) < 13) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_sample  <= s;
      req_seq_end <= ends;
      do @(posedge clock); while (req_stall);
   endtask

   // Holds the sender off until every expected median is back, then lets the
   // pipeline empty of samples that produce nothing.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (open_results != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(input logic reg_index,
                            input logic [swm_pkg::CSR_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_index, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Mostly full-range values, with extremes and a narrow band that makes
   // duplicates common.
   function automatic swm_pkg::sample_type rand_sample();
      unique case ($urandom_range(0, 9))
         0: begin
            unique case ($urandom_range(0, 3))
               0:       return S_MIN;
               1:       return S_MAX;
               2:       return swm_pkg::sample_type'(0);
               default: return swm_pkg::sample_type'(-1);
            endcase
         end
         1, 2, 3: return swm_pkg::sample_type'(int'($urandom_range(0, 8)) - 4);
         default: return swm_pkg::sample_type'($urandom);
      endcase
   endfunction

   task automatic run_phase(input int wl, input int count, input int pause_at);
      int len;
      int left;
      int seq;
      len  = (wl < 1) ? 1 : ((wl > 64) ? 64 : wl);
      left = count;
      settle();
      write_reg(swm_pkg::REG_WINDOW_LEN, swm_pkg::CSR_W'(wl));
      while (left > 0) begin
         if (len > 1 && $urandom_range(0, 99) < 15)
            seq = $urandom_range(1, len - 1);
         else
            seq = $urandom_range(len, 3 * len + 2);
         for (int k = 0; k < seq && left > 0; k++) begin
            if (left == pause_at) settle();
            push_sample(rand_sample(), k == seq - 1);
            left--;
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Default length of three: a sequence that fills and ends on one sample,
      // a lone sample, an early end with an even count, extremes and duplicates.
      push_sample(S_MIN, 1'b0);
      push_sample(S_MAX, 1'b0);
      push_sample(0, 1'b1);
      push_sample(-1, 1'b1);
      push_sample(7, 1'b0);
      push_sample(9, 1'b1);
      push_sample(S_MAX, 1'b0);
      push_sample(S_MAX, 1'b0);
      push_sample(S_MAX, 1'b0);
      push_sample(S_MIN, 1'b0);
      push_sample(S_MIN, 1'b0);
      push_sample(S_MIN, 1'b1);
      push_sample(4, 1'b0);
      push_sample(4, 1'b0);
      push_sample(2, 1'b0);
      push_sample(4, 1'b1);

      // A zero length acts as one; a write to the spare register changes nothing.
      settle();
      write_reg(swm_pkg::REG_WINDOW_LEN, '0);
      push_sample(5, 1'b0);
      push_sample(-3, 1'b1);
      settle();
      write_reg(SPARE_REG, swm_pkg::CSR_W'(10));
      push_sample(1, 1'b0);
      push_sample(2, 1'b1);

      // Even window: the sum of the two middle values at both extremes.
      settle();
      write_reg(swm_pkg::REG_WINDOW_LEN, swm_pkg::CSR_W'(2));
      push_sample(S_MAX, 1'b0);
      push_sample(S_MAX, 1'b1);
      push_sample(S_MIN, 1'b0);
      push_sample(S_MAX, 1'b1);

      run_phase(5, 80, 40);
      run_phase(1, 50, -1);
      run_phase(64, 160, -1);
      steady = 1'b1;
      run_phase(127, 90, -1);
      steady = 1'b0;
      run_phase(2, 60, -1);
      run_phase(0, 40, -1);
      run_phase(65, 70, -1);
      run_phase(4, 70, -1);
      run_phase($urandom_range(1, 40), 70, -1);
      run_phase(3, 60, -1);

      settle();
      repeat (4) @(posedge clock);
      if (fail_count == 0 && open_results == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

FILE: files.f
sv/swm_pkg.sv
sv/swm_cell.sv
sv/swm_mid_sel.sv
sv/sliding_window_median.sv
sv/swm_checker.sv
tb/swm_median_checker.sv
tb/tb.sv
